>>> rtl/core/phq_pkg.sv
package phq_pkg;

    localparam int SAMPLE_BITS   = 8;
    localparam int COUNT_BITS    = 32;
    localparam int MAX_QUANTILES = 16;

    localparam int NUM_BINS  = 1 << SAMPLE_BITS;
    localparam int RANK_BITS = $clog2(MAX_QUANTILES + 1);
    localparam int TOT_BITS  = COUNT_BITS + SAMPLE_BITS;
    localparam int PROD_BITS = COUNT_BITS + RANK_BITS;
    localparam int CUMN_BITS = TOT_BITS + RANK_BITS;
    localparam int MIN_ORDER = 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // APB register map
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_LSB   = 2;

    typedef logic cfg_idx_t;
    localparam cfg_idx_t REG_MAX_SAMPLE  = 1'b0;
    localparam cfg_idx_t REG_QUANT_ORDER = 1'b1;

    localparam int REQ_BITS = 2;
    typedef enum logic [REQ_BITS-1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_READ   = 2'd1,
        REQ_QUANT  = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_type_t;

    localparam logic RES_BIN   = 1'b0;
    localparam logic RES_QUANT = 1'b1;

    typedef struct packed {
        logic smp;      // pixel sample accepted
        logic clr;      // clear accepted
        logic start;    // bin read or quantile request accepted
        logic walk;     // issue a totaling read and advance the bin pointer
        logic q_init;   // set up the quantile search
        logic q_rd;     // read the bin under the pointer
        logic q_mul;    // scale the read count by the order
        logic q_add;    // add the scaled count to the running sum
        logic v_inc;    // advance the bin pointer
        logic q_emit;   // load one quantile result
        logic r_emit;   // load the bin readout result
    } phq_cmd_t;

    typedef struct packed {
        logic v_last;
        logic q_adv;
        logic k_last;
        logic out_busy;
    } phq_status_t;

    function automatic logic [COUNT_BITS-1:0] sat_count(input logic [TOT_BITS-1:0] v);
        logic [COUNT_BITS-1:0] r;
        if (|v[TOT_BITS-1:COUNT_BITS]) begin
            r = COUNT_MAX;
        end
        else begin
            r = v[COUNT_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic [RANK_BITS-1:0] clamp_order(input logic [RANK_BITS-1:0] o);
        logic [RANK_BITS-1:0] r;
        if (o < RANK_BITS'(MIN_ORDER)) begin
            r = RANK_BITS'(MIN_ORDER);
        end
        else if (o > RANK_BITS'(MAX_QUANTILES)) begin
            r = RANK_BITS'(MAX_QUANTILES);
        end
        else begin
            r = o;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/phq_if.sv
interface phq_req_if;
    import phq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [REQ_BITS-1:0]    req_type;
    logic [SAMPLE_BITS-1:0] sample_value;
    logic [SAMPLE_BITS-1:0] bin_index;

    modport source (output valid, req_type, sample_value, bin_index, input ready);
    modport sink   (input valid, req_type, sample_value, bin_index, output ready);
endinterface

interface phq_res_if;
    import phq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   result_kind;
    logic [SAMPLE_BITS-1:0] bin_value;
    logic [COUNT_BITS-1:0]  bin_count;
    logic [COUNT_BITS-1:0]  count_at_or_below;
    logic [COUNT_BITS-1:0]  count_at_or_above;
    logic [RANK_BITS-1:0]   quantile_rank;
    logic [SAMPLE_BITS-1:0] quantile_value;
    logic                   last;

    modport source (output valid, result_kind, bin_value, bin_count, count_at_or_below,
                    count_at_or_above, quantile_rank, quantile_value, last, input ready);
    modport sink   (input valid, result_kind, bin_value, bin_count, count_at_or_below,
                    count_at_or_above, quantile_rank, quantile_value, last, output ready);
endinterface

>>> rtl/core/phq_ctrl.sv
module phq_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [phq_pkg::REQ_BITS-1:0]  in_type,
    output logic                          in_ready,
    input  phq_pkg::phq_status_t          status,
    output phq_pkg::phq_cmd_t             cmd
);
    import phq_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_WALK  = 9'b000000010,
        S_WLAST = 9'b000000100,
        S_RFIN  = 9'b000001000,
        S_QINIT = 9'b000010000,
        S_QREAD = 9'b000100000,
        S_QDATA = 9'b001000000,
        S_QADD  = 9'b010000000,
        S_QTEST = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   is_q_reg, is_q_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            is_q_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            is_q_reg  <= is_q_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        is_q_next  = is_q_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (req_type_t'(in_type))
                        REQ_SAMPLE: cmd.smp = 1'b1;
                        REQ_CLEAR:  cmd.clr = 1'b1;
                        REQ_READ:
                        begin
                            cmd.start  = 1'b1;
                            is_q_next  = 1'b0;
                            state_next = S_WALK;
                        end
                        REQ_QUANT:
                        begin
                            cmd.start  = 1'b1;
                            is_q_next  = 1'b1;
                            state_next = S_WALK;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (status.v_last)
                begin
                    state_next = S_WLAST;
                end
            end
            // last bin is still being summed
            S_WLAST: state_next = is_q_reg ? S_QINIT : S_RFIN;
            S_RFIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.r_emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_QINIT:
            begin
                cmd.q_init = 1'b1;
                state_next = S_QREAD;
            end
            S_QREAD:
            begin
                cmd.q_rd   = 1'b1;
                state_next = S_QDATA;
            end
            S_QDATA:
            begin
                cmd.q_mul  = 1'b1;
                state_next = S_QADD;
            end
            S_QADD:
            begin
                cmd.q_add  = 1'b1;
                state_next = S_QTEST;
            end
            S_QTEST:
            begin
                if (status.q_adv)
                begin
                    cmd.v_inc  = 1'b1;
                    state_next = S_QREAD;
                end
                else if (!status.out_busy)
                begin
                    cmd.q_emit = 1'b1;
                    if (status.k_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

>>> rtl/core/phq_datapath.sv
module phq_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  phq_pkg::phq_cmd_t                cmd,
    output phq_pkg::phq_status_t             status,
    input  logic [phq_pkg::SAMPLE_BITS-1:0]  sample_value,
    input  logic [phq_pkg::SAMPLE_BITS-1:0]  bin_index,
    input  logic [phq_pkg::SAMPLE_BITS-1:0]  max_value,
    input  logic [phq_pkg::RANK_BITS-1:0]    order,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic                             out_result_kind,
    output logic [phq_pkg::SAMPLE_BITS-1:0]  out_bin_value,
    output logic [phq_pkg::COUNT_BITS-1:0]   out_bin_count,
    output logic [phq_pkg::COUNT_BITS-1:0]   out_count_at_or_below,
    output logic [phq_pkg::COUNT_BITS-1:0]   out_count_at_or_above,
    output logic [phq_pkg::RANK_BITS-1:0]    out_quantile_rank,
    output logic [phq_pkg::SAMPLE_BITS-1:0]  out_quantile_value,
    output logic                             out_last
);
    import phq_pkg::*;

    // bin store; an entry not marked valid reads as zero
    logic [COUNT_BITS-1:0]  mem [NUM_BINS];
    logic [NUM_BINS-1:0]    bin_vld_reg;
    logic [COUNT_BITS-1:0]  rdata_reg;
    logic                   rvld_reg;

    logic                   rd_en;
    logic [SAMPLE_BITS-1:0] rd_addr;
    logic [COUNT_BITS-1:0]  rd_val;

    // increment stage
    logic                   smp_ok;
    logic                   s1_vld_reg;
    logic [SAMPLE_BITS-1:0] s1_addr_reg;
    logic                   hit_reg;
    logic [COUNT_BITS-1:0]  fwd_reg;
    logic [COUNT_BITS-1:0]  old_cnt;
    logic [COUNT_BITS-1:0]  new_cnt;

    // walk and quantile search
    logic [SAMPLE_BITS-1:0] v_reg;
    logic                   walk_d_reg;
    logic [SAMPLE_BITS-1:0] a_d_reg;
    logic [SAMPLE_BITS-1:0] bin_reg;
    logic [RANK_BITS-1:0]   n_reg;
    logic [TOT_BITS-1:0]    total_reg;
    logic [TOT_BITS-1:0]    below_reg;
    logic [COUNT_BITS-1:0]  cnt_reg;
    logic [TOT_BITS-1:0]    above_tot;
    logic [RANK_BITS-1:0]   k_reg;
    logic [CUMN_BITS-1:0]   kt_reg;
    logic [CUMN_BITS-1:0]   cum_n_reg;
    logic [PROD_BITS-1:0]   prod_reg;

    logic                   out_vld_reg;
    logic                   out_kind_reg;
    logic [SAMPLE_BITS-1:0] out_bval_reg;
    logic [COUNT_BITS-1:0]  out_bcnt_reg;
    logic [COUNT_BITS-1:0]  out_below_reg;
    logic [COUNT_BITS-1:0]  out_above_reg;
    logic [RANK_BITS-1:0]   out_rank_reg;
    logic [SAMPLE_BITS-1:0] out_qval_reg;
    logic                   out_last_reg;

    assign smp_ok  = cmd.smp && (sample_value <= max_value);
    assign rd_en   = cmd.smp || cmd.walk || cmd.q_rd;
    assign rd_addr = cmd.smp ? sample_value : v_reg;
    assign rd_val  = rvld_reg ? rdata_reg : '0;
    // forward the count written in the same edge the read was taken
    assign old_cnt = hit_reg ? fwd_reg : rd_val;
    assign new_cnt = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + COUNT_BITS'(1);

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            mem[s1_addr_reg] <= new_cnt;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_vld_reg <= '0;
            rvld_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            s1_vld_reg  <= 1'b0;
            walk_d_reg  <= 1'b0;
            v_reg       <= '0;
            k_reg       <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            // a clear follows any pending increment, so it wins
            if (cmd.clr)
            begin
                bin_vld_reg <= '0;
            end
            else if (s1_vld_reg)
            begin
                bin_vld_reg[s1_addr_reg] <= 1'b1;
            end
            if (rd_en)
            begin
                rvld_reg <= bin_vld_reg[rd_addr];
                hit_reg  <= cmd.smp && s1_vld_reg && (sample_value == s1_addr_reg);
            end
            s1_vld_reg <= smp_ok;
            walk_d_reg <= cmd.walk;

            if (cmd.start || cmd.q_init)
            begin
                v_reg <= '0;
            end
            else if (cmd.walk || cmd.v_inc)
            begin
                v_reg <= v_reg + SAMPLE_BITS'(1);
            end

            if (cmd.q_init)
            begin
                k_reg <= RANK_BITS'(1);
            end
            else if (cmd.q_emit)
            begin
                k_reg <= k_reg + RANK_BITS'(1);
            end

            if (cmd.r_emit || cmd.q_emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign above_tot = total_reg - below_reg + TOT_BITS'(cnt_reg);

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= sample_value;
        fwd_reg     <= new_cnt;
        a_d_reg     <= v_reg;

        if (cmd.start)
        begin
            total_reg <= '0;
            below_reg <= '0;
            cnt_reg   <= '0;
            bin_reg   <= bin_index;
            n_reg     <= clamp_order(order);
        end
        else if (walk_d_reg)
        begin
            total_reg <= total_reg + TOT_BITS'(rd_val);
            if (a_d_reg <= bin_reg)
            begin
                below_reg <= below_reg + TOT_BITS'(rd_val);
            end
            if (a_d_reg == bin_reg)
            begin
                cnt_reg <= rd_val;
            end
        end

        if (cmd.q_init)
        begin
            kt_reg    <= CUMN_BITS'(total_reg);
            cum_n_reg <= '0;
        end
        else
        begin
            if (cmd.q_emit)
            begin
                kt_reg <= kt_reg + CUMN_BITS'(total_reg);
            end
            if (cmd.q_add)
            begin
                cum_n_reg <= cum_n_reg + CUMN_BITS'(prod_reg);
            end
        end

        if (cmd.q_mul)
        begin
            prod_reg <= PROD_BITS'(rd_val) * PROD_BITS'(n_reg);
        end

        if (cmd.r_emit)
        begin
            out_kind_reg  <= RES_BIN;
            out_bval_reg  <= bin_reg;
            out_bcnt_reg  <= cnt_reg;
            out_below_reg <= sat_count(below_reg);
            out_above_reg <= sat_count(above_tot);
            out_rank_reg  <= '0;
            out_qval_reg  <= '0;
            out_last_reg  <= 1'b1;
        end
        else if (cmd.q_emit)
        begin
            out_kind_reg  <= RES_QUANT;
            out_bval_reg  <= '0;
            out_bcnt_reg  <= '0;
            out_below_reg <= '0;
            out_above_reg <= '0;
            out_rank_reg  <= k_reg;
            out_qval_reg  <= v_reg;
            out_last_reg  <= (k_reg == n_reg);
        end
    end

    assign status.v_last   = (v_reg == max_value);
    assign status.q_adv    = (cum_n_reg < kt_reg) && (v_reg != max_value);
    assign status.k_last   = (k_reg == n_reg);
    assign status.out_busy = out_vld_reg && !out_ready;

    assign out_valid             = out_vld_reg;
    assign out_result_kind       = out_kind_reg;
    assign out_bin_value         = out_bval_reg;
    assign out_bin_count         = out_bcnt_reg;
    assign out_count_at_or_below = out_below_reg;
    assign out_count_at_or_above = out_above_reg;
    assign out_quantile_rank     = out_rank_reg;
    assign out_quantile_value    = out_qval_reg;
    assign out_last              = out_last_reg;

endmodule

>>> rtl/core/pixel_histogram_quantiles.sv
// Pixel samples and clears: one per cycle while idle; a count is written in the cycle after accept.
// Bin read: walks bins 0 to M (M = max_sample_value) with one bin store read per cycle
//   while the total is summed, then a drain state and a final state that registers the result.
// Quantiles: the same totaling walk, then init, then read, scale and add per bin; a test state
//   then steps to the next bin or emits one result once the output register is free.
// Reset: max_sample_value 255, quantile_order 2, all bins read as zero at once (valid bits),
//   no clearing pass; the block takes requests in the first cycle after reset.
module pixel_histogram_quantiles (
    input  logic                               clk,
    input  logic                               rst_n,
    phq_req_if.sink                            req,
    phq_res_if.source                          res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [phq_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [phq_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [phq_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                               pready
);
    import phq_pkg::*;

    // Configuration registers. Writes must land only while the block is idle; the user must
    // ensure this (not enforced by the block); max_reg is read live, order_reg latched per request.
    logic [SAMPLE_BITS-1:0] max_reg;
    logic [RANK_BITS-1:0]   order_reg;
    logic                   cfg_wr;
    cfg_idx_t               cfg_idx;

    phq_cmd_t    cmd;
    phq_status_t status;

    // Zero-wait-state APB: every access completes in its access phase.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = cfg_idx_t'(paddr[CFG_IDX_LSB]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg   <= '1;
            order_reg <= RANK_BITS'(MIN_ORDER);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_MAX_SAMPLE:  max_reg   <= pwdata[SAMPLE_BITS-1:0];
                REG_QUANT_ORDER: order_reg <= pwdata[RANK_BITS-1:0];
                default:         max_reg   <= max_reg;
            endcase
        end
    end

    // Read back the register as written; the order clamp is applied per request.
    always_comb
    begin
        unique case (cfg_idx)
            REG_MAX_SAMPLE:  prdata = CFG_DATA_BITS'(max_reg);
            REG_QUANT_ORDER: prdata = CFG_DATA_BITS'(order_reg);
            default:         prdata = '0;
        endcase
    end

    // Sequencer: accepts requests only in its idle state. Samples and clears
    // leave it idle, so they stream at full rate; bin reads and quantile
    // requests walk the bin store and hold off new requests until the last
    // result has been loaded into the output register.
    phq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_type  (req.req_type),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: bin store with valid bits, the read-increment-write stage
    // with forwarding for back-to-back samples of the same gray level,
    // the totaling walk, the scaled cumulative search for quantiles
    // (cum * n against k * total, exact), and the output register.
    phq_datapath u_dp (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cmd                   (cmd),
        .status                (status),
        .sample_value          (req.sample_value),
        .bin_index             (req.bin_index),
        .max_value             (max_reg),
        .order                 (order_reg),
        .out_ready             (res.ready),
        .out_valid             (res.valid),
        .out_result_kind       (res.result_kind),
        .out_bin_value         (res.bin_value),
        .out_bin_count         (res.bin_count),
        .out_count_at_or_below (res.count_at_or_below),
        .out_count_at_or_above (res.count_at_or_above),
        .out_quantile_rank     (res.quantile_rank),
        .out_quantile_value    (res.quantile_value),
        .out_last              (res.last)
    );

endmodule

>>> rtl/core/phq_checker.sv
module phq_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    input  logic                               req_ready,
    input  logic [phq_pkg::REQ_BITS-1:0]       req_type,
    input  logic                               res_valid,
    input  logic                               res_ready,
    input  logic                               res_result_kind,
    input  logic [phq_pkg::COUNT_BITS-1:0]     res_bin_count,
    input  logic [phq_pkg::RANK_BITS-1:0]      res_quantile_rank,
    input  logic [phq_pkg::SAMPLE_BITS-1:0]    res_quantile_value,
    input  logic                               res_last
);
    import phq_pkg::*;

    // hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_quantile_value)
            && $stable(res_bin_count) && $stable(res_last))
        else $error("stalled result changed");

    // a bin readout is always a single, final result
    a_bin_single: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_result_kind == RES_BIN) |-> res_last && (res_quantile_rank == '0))
        else $error("bin readout not final or carries a rank");

    a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_result_kind == RES_QUANT) |-> (res_quantile_rank != '0)
            && (res_quantile_rank <= RANK_BITS'(MAX_QUANTILES)) && (res_bin_count == '0))
        else $error("quantile result rank out of range");

    // a walk request blocks the request channel right away
    a_walk_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && ((req_type == REQ_READ) || (req_type == REQ_QUANT))
            |=> !req_ready)
        else $error("request taken during a walk");

endmodule

bind pixel_histogram_quantiles phq_checker u_phq_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .req_type           (req.req_type),
    .res_valid          (res.valid),
    .res_ready          (res.ready),
    .res_result_kind    (res.result_kind),
    .res_bin_count      (res.bin_count),
    .res_quantile_rank  (res.quantile_rank),
    .res_quantile_value (res.quantile_value),
    .res_last           (res.last)
);

>>> dv/histogram_checker.sv
`timescale 1ns / 1ps

module histogram_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    phq_req_if                                req,
    phq_res_if                                res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [phq_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [phq_pkg::CFG_DATA_BITS-1:0] pwdata,
    input  logic                              pready,
    output int unsigned                       mismatches,
    output int unsigned                       outstanding
);
    import phq_pkg::*;

    typedef struct packed {
        logic                   kind;
        logic [SAMPLE_BITS-1:0] bin_value;
        logic [COUNT_BITS-1:0]  bin_count;
        logic [COUNT_BITS-1:0]  at_or_below;
        logic [COUNT_BITS-1:0]  at_or_above;
        logic [RANK_BITS-1:0]   rank;
        logic [SAMPLE_BITS-1:0] qvalue;
        logic                   last;
    } histo_result_t;

    histo_result_t          expected_results [$];
    logic [COUNT_BITS-1:0]  bin_tally [NUM_BINS];
    logic [SAMPLE_BITS-1:0] level_max;
    logic [RANK_BITS-1:0]   order_setting;

    function automatic logic [COUNT_BITS-1:0] clip_to_count(input logic [63:0] v);
        return (v > 64'(COUNT_MAX)) ? COUNT_MAX : v[COUNT_BITS-1:0];
    endfunction

    // Exact sum of bins 0..upper, wide enough never to wrap.
    function automatic logic [63:0] tally_through(input int unsigned upper);
        logic [63:0] sum;
        sum = '0;
        for (int unsigned i = 0; i <= upper; i++) begin
            sum += 64'(bin_tally[i]);
        end
        return sum;
    endfunction

    task automatic predict_request(input req_type_t kind, input logic [SAMPLE_BITS-1:0] level,
                                   input logic [SAMPLE_BITS-1:0] bin);
        logic [63:0]   span_total;
        logic [63:0]   below;
        logic [63:0]   cum;
        int unsigned   n;
        int unsigned   v;
        histo_result_t r;
        case (kind)
            REQ_CLEAR: begin
                for (int i = 0; i < NUM_BINS; i++) begin
                    bin_tally[i] = '0;
                end
            end
            REQ_SAMPLE: begin
                // drop levels above the current maximum
                if (level <= level_max) begin
                    bin_tally[level] = clip_to_count(64'(bin_tally[level]) + 64'd1);
                end
            end
            REQ_READ: begin
                span_total    = tally_through(level_max);
                r             = '0;
                r.kind        = RES_BIN;
                r.bin_value   = bin;
                r.last        = 1'b1;
                if (bin > level_max) begin
                    r.at_or_below = clip_to_count(span_total);
                end
                else begin
                    below         = tally_through(bin);
                    r.bin_count   = bin_tally[bin];
                    r.at_or_below = clip_to_count(below);
                    r.at_or_above = clip_to_count(span_total - below + 64'(bin_tally[bin]));
                end
                expected_results.push_back(r);
            end
            default: begin
                span_total = tally_through(level_max);
                n = order_setting;
                if (n < MIN_ORDER) begin
                    n = MIN_ORDER;
                end
                if (n > MAX_QUANTILES) begin
                    n = MAX_QUANTILES;
                end
                v   = 0;
                cum = 64'(bin_tally[0]);
                for (int unsigned k = 1; k <= n; k++) begin
                    // advance until cum/total reaches k/n, exact integer test
                    while ((cum * n < k * span_total) && (v < level_max)) begin
                        v++;
                        cum += 64'(bin_tally[v]);
                    end
                    r        = '0;
                    r.kind   = RES_QUANT;
                    r.rank   = RANK_BITS'(k);
                    r.qvalue = SAMPLE_BITS'(v);
                    r.last   = (k == n);
                    expected_results.push_back(r);
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [COUNT_BITS-1:0] want,
                               input logic [COUNT_BITS-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_result(input histo_result_t want, input histo_result_t got);
        check_field("result_kind", 32'(want.kind), 32'(got.kind));
        check_field("bin_value", 32'(want.bin_value), 32'(got.bin_value));
        check_field("bin_count", want.bin_count, got.bin_count);
        check_field("count_at_or_below", want.at_or_below, got.at_or_below);
        check_field("count_at_or_above", want.at_or_above, got.at_or_above);
        check_field("quantile_rank", 32'(want.rank), 32'(got.rank));
        check_field("quantile_value", 32'(want.qvalue), 32'(got.qvalue));
        check_field("last", 32'(want.last), 32'(got.last));
    endtask

    always @(posedge clk or negedge rst_n) begin : monitor
        histo_result_t got;
        histo_result_t want;
        if (!rst_n) begin
            expected_results.delete();
            for (int i = 0; i < NUM_BINS; i++) begin
                bin_tally[i] = '0;
            end
            level_max     = 8'd255;
            order_setting = RANK_BITS'(MIN_ORDER);
            mismatches    = 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                if (cfg_idx_t'(paddr[CFG_IDX_LSB]) == REG_MAX_SAMPLE) begin
                    level_max = pwdata[SAMPLE_BITS-1:0];
                end
                else begin
                    order_setting = pwdata[RANK_BITS-1:0];
                end
            end
            if (req.valid && req.ready) begin
                predict_request(req_type_t'(req.req_type), req.sample_value, req.bin_index);
            end
            if (res.valid && res.ready) begin
                got.kind        = res.result_kind;
                got.bin_value   = res.bin_value;
                got.bin_count   = res.bin_count;
                got.at_or_below = res.count_at_or_below;
                got.at_or_above = res.count_at_or_above;
                got.rank        = res.quantile_rank;
                got.qvalue      = res.quantile_value;
                got.last        = res.last;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected, expected nothing actual %0h",
                             $time, got);
                    mismatches++;
                end
                else begin
                    want = expected_results.pop_front();
                    compare_result(want, got);
                end
            end
        end
        outstanding = expected_results.size();
    end

endmodule

>>> dv/tb_pixel_histogram_quantiles.sv
`timescale 1ns / 1ps

module tb_pixel_histogram_quantiles;
    import phq_pkg::*;

    localparam int CLK_PERIOD    = 20;
    // sample counts land in the cycle after accept; leave margin before a register write
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 1400;
    // sized for a worst case of ~460 quantile requests, taken several times over
    localparam longint TIMEOUT_NS = 64'd60_000_000;

    logic clk;
    logic rst_n;

    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    int unsigned mismatches;
    int unsigned outstanding;

    // idle bursts on both channels while set; cleared for the last part of the run
    bit idle_enabled;
    // maximum as last written, used only to bias stimulus toward valid levels
    logic [SAMPLE_BITS-1:0] cur_max;

    phq_req_if req_ch ();
    phq_res_if res_ch ();

    pixel_histogram_quantiles DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    histogram_checker u_histogram_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .res         (res_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Watchdog: end the run if the histogram stops answering.
    initial begin
        #(TIMEOUT_NS);
        $display("tb_pixel_histogram_quantiles: errors");
        $finish;
    end

    // Result side: hold ready high, drop it for random bursts while idling is enabled,
    // and now and then keep it high for a long stretch.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (idle_enabled && $urandom_range(0, 7) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else if ($urandom_range(0, 31) == 0) begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    // Present one request and hold it until the block takes it. An optional idle
    // burst goes in front; valid is never lowered and raised in the same step.
    task automatic send_request(input req_type_t kind, input logic [SAMPLE_BITS-1:0] level,
                                input logic [SAMPLE_BITS-1:0] bin);
        if (idle_enabled && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.sample_value <= level;
        req_ch.bin_index    <= bin;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // Drop valid and wait until every expected result is in and the last
    // sample count has been written back.
    task automatic settle();
        req_ch.valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle held until pready, then the bus returns to idle.
    task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_BITS'(idx) << CFG_IDX_LSB;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (idx == REG_MAX_SAMPLE) begin
            cur_max = value[SAMPLE_BITS-1:0];
        end
    endtask

    // Mostly samples, a fair share of bin reads and quantile requests, rare clears.
    // Levels lean toward the valid range; the rest probe dropped samples and
    // out-of-range bin reads.
    task automatic random_requests(input int unsigned count);
        req_type_t              kind;
        int unsigned            roll;
        logic [SAMPLE_BITS-1:0] level;
        logic [SAMPLE_BITS-1:0] bin;
        for (int unsigned i = 0; i < count; i++) begin
            roll  = $urandom_range(0, 99);
            level = ($urandom_range(0, 3) == 0) ? SAMPLE_BITS'($urandom_range(0, 255))
                                                : SAMPLE_BITS'($urandom_range(0, cur_max));
            bin   = ($urandom_range(0, 1) == 0) ? SAMPLE_BITS'($urandom_range(0, 255))
                                                : SAMPLE_BITS'($urandom_range(0, cur_max));
            if (roll < 68) begin
                kind = REQ_SAMPLE;
            end
            else if (roll < 84) begin
                kind = REQ_READ;
            end
            else if (roll < 97) begin
                kind = REQ_QUANT;
            end
            else begin
                kind = REQ_CLEAR;
            end
            send_request(kind, level, bin);
        end
    endtask

    // Reconfigure while idle, then run a random stretch under the new setting.
    task automatic run_phase(input logic [SAMPLE_BITS-1:0] max_level,
                             input logic [RANK_BITS-1:0] order, input int unsigned count);
        settle();
        write_register(REG_MAX_SAMPLE, CFG_DATA_BITS'(max_level));
        write_register(REG_QUANT_ORDER, CFG_DATA_BITS'(order));
        random_requests(count);
    endtask

    initial begin
        rst_n               = 1'b0;
        idle_enabled        = 1'b1;
        cur_max             = 8'd255;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_SAMPLE;
        req_ch.sample_value = '0;
        req_ch.bin_index    = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset settings (maximum 255, median).
        // Empty histogram: quantiles all zero, reads all zero.
        send_request(REQ_QUANT, 8'h00, 8'h00);
        send_request(REQ_READ, 8'h00, 8'h00);
        send_request(REQ_READ, 8'hFF, 8'hFF);
        // Extremes and alternating bit patterns of the level.
        send_request(REQ_SAMPLE, 8'h00, 8'hFF);
        send_request(REQ_SAMPLE, 8'hFF, 8'h00);
        send_request(REQ_SAMPLE, 8'h55, 8'hAA);
        send_request(REQ_SAMPLE, 8'hAA, 8'h55);
        send_request(REQ_SAMPLE, 8'hFF, 8'h00);
        send_request(REQ_SAMPLE, 8'h80, 8'h00);
        send_request(REQ_READ, 8'hFF, 8'h00);
        send_request(REQ_READ, 8'h00, 8'hFF);
        send_request(REQ_READ, 8'h00, 8'hAA);
        send_request(REQ_READ, 8'h00, 8'h37);
        send_request(REQ_QUANT, 8'h00, 8'h00);
        // Clear, then check the store reads empty again.
        send_request(REQ_CLEAR, 8'hFF, 8'hFF);
        send_request(REQ_READ, 8'h00, 8'hFF);
        send_request(REQ_QUANT, 8'h00, 8'h00);
        // All mass in one bin, plus one high bin to be hidden by a lower maximum.
        send_request(REQ_SAMPLE, 8'h07, 8'h00);
        send_request(REQ_SAMPLE, 8'h07, 8'h00);
        send_request(REQ_SAMPLE, 8'hFA, 8'h00);
        send_request(REQ_QUANT, 8'h00, 8'h00);

        // Lowered maximum: the high bin keeps its count but drops out of every sum;
        // a sample above the maximum is dropped; reads above it are out of range.
        settle();
        write_register(REG_MAX_SAMPLE, 32'd100);
        write_register(REG_QUANT_ORDER, 32'd4);
        send_request(REQ_SAMPLE, 8'hC8, 8'h00);
        send_request(REQ_SAMPLE, 8'h64, 8'h00);
        send_request(REQ_READ, 8'h00, 8'hFA);
        send_request(REQ_READ, 8'h00, 8'h64);
        send_request(REQ_QUANT, 8'h00, 8'h00);
        random_requests(30);

        // Walk the settings: both extremes of each register, and orders below 2
        // and above the quantile limit, which clamp.
        run_phase(8'd0, 5'd0, 50);
        run_phase(8'd1, 5'd16, 50);
        run_phase(8'd255, 5'd31, 55);
        run_phase(8'd37, 5'd10, 55);
        run_phase(8'd200, 5'd1, 55);
        run_phase(8'd15, 5'd3, 50);

        // Last part: no idling on either side.
        idle_enabled = 1'b0;
        run_phase(8'd255, 5'd17, 45);
        run_phase(SAMPLE_BITS'($urandom_range(1, 255)), RANK_BITS'($urandom_range(2, 16)), 45);

        // Drain: wait for every expected result, then watch for stray ones.
        req_ch.valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_pixel_histogram_quantiles: clean");
        end
        else begin
            $display("tb_pixel_histogram_quantiles: errors");
        end
        $finish;
    end

endmodule
